FILE: rtl/bsc_pkg.sv
// Shared constants, types and control codes for the binary search core.
package bsc_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(DEPTH);
  // Signed bound width: low reaches DEPTH, high reaches -1.
  localparam int BOUND_W     = ADDR_W + 2;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE
  } state_t;

  typedef struct packed {
    logic write_elem;
    logic load_range;
    logic narrow;
    logic finish_hit;
    logic finish_miss;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty;
    logic equal;
  } ctrl_status_t;

endpackage

FILE: rtl/bsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bsc_ctrl.sv
// Controller state machine sequencing loads and search probes.
module bsc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  req_type,
  input  bsc_pkg::ctrl_status_t status,
  output bsc_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  bsc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      bsc_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (req_type == bsc_pkg::REQ_SEARCH) begin
            cmd.load_range = 1'b1;
            state_next     = bsc_pkg::ST_PROBE;
          end else begin
            cmd.write_elem = 1'b1;
          end
        end
      end
      bsc_pkg::ST_PROBE: begin
        // Read of the midpoint is issued in this cycle when the range is not empty.
        if (status.empty) begin
          cmd.finish_miss = 1'b1;
          state_next      = bsc_pkg::ST_IDLE;
        end else begin
          state_next = bsc_pkg::ST_COMPARE;
        end
      end
      bsc_pkg::ST_COMPARE: begin
        if (status.equal) begin
          cmd.finish_hit = 1'b1;
          state_next     = bsc_pkg::ST_IDLE;
        end else begin
          cmd.narrow = 1'b1;
          state_next = bsc_pkg::ST_PROBE;
        end
      end
      default: begin
        state_next = bsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/bsc_dp.sv
// Datapath: search bounds, midpoint, element store and result registers.
module bsc_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bsc_pkg::ctrl_cmd_t                  cmd,
  output bsc_pkg::ctrl_status_t               status,
  input  logic [bsc_pkg::ADDR_W-1:0]          elem_index,
  input  logic signed [bsc_pkg::VALUE_WIDTH-1:0] elem_value,
  input  logic [bsc_pkg::ADDR_W-1:0]          range_low,
  input  logic [bsc_pkg::ADDR_W-1:0]          range_high,
  input  logic signed [bsc_pkg::VALUE_WIDTH-1:0] target_value,
  output logic                                done,
  output logic                                found,
  output logic [bsc_pkg::ADDR_W-1:0]          found_index
);

  logic signed [bsc_pkg::BOUND_W-1:0]     low, high;
  logic signed [bsc_pkg::BOUND_W-1:0]     low_next, high_next;
  logic signed [bsc_pkg::BOUND_W-1:0]     sum;
  logic [bsc_pkg::ADDR_W-1:0]             mid, mid_q;
  logic signed [bsc_pkg::VALUE_WIDTH-1:0] target;
  logic signed [bsc_pkg::VALUE_WIDTH-1:0] probed;
  logic [bsc_pkg::VALUE_WIDTH-1:0]        rdata;

  assign sum    = low + high;
  assign mid    = sum[bsc_pkg::ADDR_W:1];
  assign probed = $signed(rdata);

  assign status.empty = (low > high);
  assign status.equal = (probed == target);

  bsc_ram #(
    .WIDTH(bsc_pkg::VALUE_WIDTH),
    .DEPTH(bsc_pkg::DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write_elem),
    .waddr(elem_index),
    .wdata(elem_value),
    .raddr(mid),
    .rdata(rdata)
  );

  // Load the search range, or keep the half that can still hold the target.
  always_comb begin
    low_next  = low;
    high_next = high;
    if (cmd.load_range) begin
      low_next  = $signed({2'b00, range_low});
      high_next = $signed({2'b00, range_high});
    end else if (cmd.narrow) begin
      if (probed > target) begin
        high_next = $signed({2'b00, mid_q}) - $signed(bsc_pkg::BOUND_W'(1));
      end else begin
        low_next = $signed({2'b00, mid_q}) + $signed(bsc_pkg::BOUND_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    low   <= low_next;
    high  <= high_next;
    mid_q <= mid;
    if (cmd.load_range) begin
      target <= target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish_hit | cmd.finish_miss;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish_hit) begin
      found       <= 1'b1;
      found_index <= mid_q;
    end else if (cmd.finish_miss) begin
      found       <= 1'b0;
      found_index <= '0;
    end
  end

endmodule

FILE: rtl/sorted_array_binary_search_core.sv
// Top level of the binary search core: controller plus datapath.
// A load (req_type 0) writes one 32-bit signed element in the cycle it is taken and
// gives no result. A search (req_type 1) runs its probes in turn: ST_PROBE reads the
// store at the midpoint and ST_COMPARE compares the word read and narrows the range,
// and an empty range is reported as a miss from ST_PROBE. The registered read of the
// element store is why each probe needs both states. busy is high while a search
// runs; the result appears on found and found_index for exactly one cycle with done
// high, and there is no way to hold it off, so sample it then. A new item may be
// started in that same cycle.
module sorted_array_binary_search_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   req_type,
  input  logic [bsc_pkg::ADDR_W-1:0]             elem_index,
  input  logic signed [bsc_pkg::VALUE_WIDTH-1:0] elem_value,
  input  logic [bsc_pkg::ADDR_W-1:0]             range_low,
  input  logic [bsc_pkg::ADDR_W-1:0]             range_high,
  input  logic signed [bsc_pkg::VALUE_WIDTH-1:0] target_value,
  output logic                                   done,
  output logic                                   found,
  output logic [bsc_pkg::ADDR_W-1:0]             found_index
);

  bsc_pkg::ctrl_cmd_t    cmd;
  bsc_pkg::ctrl_status_t status;

  bsc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req_type(req_type),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  bsc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .elem_index  (elem_index),
    .elem_value  (elem_value),
    .range_low   (range_low),
    .range_high  (range_high),
    .target_value(target_value),
    .done        (done),
    .found       (found),
    .found_index (found_index)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the binary search core: predicted lookups against done strobes.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_ITEMS     = 1750;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_WAIT  = 30;

  localparam logic signed [bsc_pkg::VALUE_WIDTH-1:0] VAL_MIN =
    {1'b1, {(bsc_pkg::VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [bsc_pkg::VALUE_WIDTH-1:0] VAL_MAX = ~VAL_MIN;

  typedef struct {
    logic                                   req;
    logic [bsc_pkg::ADDR_W-1:0]             eidx;
    logic signed [bsc_pkg::VALUE_WIDTH-1:0] evalue;
    logic [bsc_pkg::ADDR_W-1:0]             rlo;
    logic [bsc_pkg::ADDR_W-1:0]             rhi;
    logic signed [bsc_pkg::VALUE_WIDTH-1:0] key;
    bit                                     hit;
    logic [bsc_pkg::ADDR_W-1:0]             at;
  } core_req_t;

  typedef struct {
    bit                         hit;
    logic [bsc_pkg::ADDR_W-1:0] at;
  } lookup_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   start = 1'b0;
  logic                                   req_type = bsc_pkg::REQ_LOAD;
  logic [bsc_pkg::ADDR_W-1:0]             elem_index = '0;
  logic signed [bsc_pkg::VALUE_WIDTH-1:0] elem_value = '0;
  logic [bsc_pkg::ADDR_W-1:0]             range_low = '0;
  logic [bsc_pkg::ADDR_W-1:0]             range_high = '0;
  logic signed [bsc_pkg::VALUE_WIDTH-1:0] target_value = '0;
  logic                                   busy;
  logic                                   done;
  logic                                   found;
  logic [bsc_pkg::ADDR_W-1:0]             found_index;

  // predicted contents of the element store
  logic signed [bsc_pkg::VALUE_WIDTH-1:0] elem_store [bsc_pkg::DEPTH];
  bit                                     written [bsc_pkg::DEPTH];

  core_req_t req_backlog[$];
  lookup_t   search_results_due[$];
  core_req_t cur;
  int        burst_left = 1;
  int        gap_left = 0;
  int        fault_count = 0;
  int        idle_cycles = 0;

  sorted_array_binary_search_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .elem_index   (elem_index),
    .elem_value   (elem_value),
    .range_low    (range_low),
    .range_high   (range_high),
    .target_value (target_value),
    .done         (done),
    .found        (found),
    .found_index  (found_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk the probe sequence; return 0 if it would touch an unwritten entry.
  function automatic bit walk_search(input int lo_in, input int hi_in,
                                     input logic signed [bsc_pkg::VALUE_WIDTH-1:0] key,
                                     output bit hit,
                                     output logic [bsc_pkg::ADDR_W-1:0] at);
    int lo;
    int hi;
    int mid;
    lo  = lo_in;
    hi  = (hi_in > bsc_pkg::DEPTH - 1) ? bsc_pkg::DEPTH - 1 : hi_in;
    hit = 1'b0;
    at  = '0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (!written[mid]) return 1'b0;
      if (elem_store[mid] == key) begin
        hit = 1'b1;
        at  = mid[bsc_pkg::ADDR_W-1:0];
        return 1'b1;
      end else if (elem_store[mid] > key) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic signed [bsc_pkg::VALUE_WIDTH-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return int'($urandom_range(0, 20)) - 10;
      default: return $urandom();
    endcase
  endfunction

  function automatic void add_load(input int idx,
                                   input logic signed [bsc_pkg::VALUE_WIDTH-1:0] v);
    core_req_t it;
    it.req    = bsc_pkg::REQ_LOAD;
    it.eidx   = idx[bsc_pkg::ADDR_W-1:0];
    it.evalue = v;
    it.rlo    = bsc_pkg::ADDR_W'($urandom_range(0, bsc_pkg::DEPTH - 1));
    it.rhi    = bsc_pkg::ADDR_W'($urandom_range(0, bsc_pkg::DEPTH - 1));
    it.key    = $urandom();
    it.hit    = 1'b0;
    it.at     = '0;
    elem_store[idx] = v;
    written[idx]    = 1'b1;
    req_backlog.push_back(it);
  endfunction

  // Queue a search only if its probes stay on written entries.
  function automatic bit add_search(input int lo, input int hi,
                                    input logic signed [bsc_pkg::VALUE_WIDTH-1:0] key);
    core_req_t                  it;
    bit                         hit;
    logic [bsc_pkg::ADDR_W-1:0] at;
    if (!walk_search(lo, hi, key, hit, at)) return 1'b0;
    it.req    = bsc_pkg::REQ_SEARCH;
    it.eidx   = bsc_pkg::ADDR_W'($urandom_range(0, bsc_pkg::DEPTH - 1));
    it.evalue = $urandom();
    it.rlo    = lo[bsc_pkg::ADDR_W-1:0];
    it.rhi    = hi[bsc_pkg::ADDR_W-1:0];
    it.key    = key;
    it.hit    = hit;
    it.at     = at;
    req_backlog.push_back(it);
    return 1'b1;
  endfunction

  // Sender: bursts of transfers separated by random gaps.
  always @(posedge clk) begin : drive_p
    bit take_next;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take_next = !start;
      if (start && !busy) begin
        if (cur.req == bsc_pkg::REQ_SEARCH) search_results_due.push_back('{cur.hit, cur.at});
        take_next = 1'b1;
      end
      if (take_next) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur = req_backlog.pop_front();
          req_type     <= cur.req;
          elem_index   <= cur.eidx;
          elem_value   <= cur.evalue;
          range_low    <= cur.rlo;
          range_high   <= cur.rhi;
          target_value <= cur.key;
          start        <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_p
    lookup_t due;
    if (!rst && done) begin
      if (search_results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("tb: unexpected result found=%0b index=%0d", found, found_index);
      end else begin
        due = search_results_due.pop_front();
        if (found !== due.hit || found_index !== due.at) begin
          fault_count++;
          if (fault_count <= 10)
            $display("tb: mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                     due.hit, due.at, found, found_index);
        end
      end
    end
  end

  // End the run when neither side transfers for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stim_p
    int n;
    int base;
    int lo;
    int hi;
    int j;
    int nsearch;
    bit narrow;
    int vals[$];
    logic signed [bsc_pkg::VALUE_WIDTH-1:0] key;

    // directed: extremes, duplicates, empty ranges, unsorted data
    add_load(0, VAL_MIN);
    add_load(1, -5);
    add_load(2, 7);
    add_load(3, 7);
    add_load(4, 7);
    add_load(5, 50);
    add_load(6, -50);
    add_load(511, 0);
    add_load(1022, 100);
    add_load(bsc_pkg::DEPTH - 1, VAL_MAX);
    void'(add_search(0, 0, VAL_MIN));
    void'(add_search(bsc_pkg::DEPTH - 1, bsc_pkg::DEPTH - 1, VAL_MAX));
    void'(add_search(0, bsc_pkg::DEPTH - 1, 0));
    void'(add_search(5, 3, 1));
    void'(add_search(bsc_pkg::DEPTH - 1, 0, 0));
    void'(add_search(511, 511, 1));
    void'(add_search(0, 1, -5));
    void'(add_search(2, 4, 7));
    void'(add_search(0, 6, 7));
    void'(add_search(5, 6, -50));
    void'(add_search(1022, bsc_pkg::DEPTH - 1, 100));
    void'(add_search(1022, bsc_pkg::DEPTH - 1, VAL_MAX));

    // random: load a window, sorted in most cases, then search mostly within it
    while (req_backlog.size() < N_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      case ($urandom_range(0, 7))
        0:       base = 0;
        1:       base = bsc_pkg::DEPTH - n;
        default: base = $urandom_range(0, bsc_pkg::DEPTH - n);
      endcase
      narrow = ($urandom_range(0, 2) == 0);
      vals.delete();
      for (int i = 0; i < n; i++)
        vals.push_back(narrow ? int'($urandom_range(0, 6)) - 3 : int'(rand_value()));
      // leave some windows unsorted
      if ($urandom_range(0, 9) != 0) vals.sort();
      for (int i = 0; i < n; i++) add_load(base + i, vals[i]);

      nsearch = $urandom_range(1, 8);
      for (int s = 0; s < nsearch; s++) begin
        case ($urandom_range(0, 9))
          0: begin
            lo = $urandom_range(1, bsc_pkg::DEPTH - 1);
            hi = $urandom_range(0, lo - 1);
            void'(add_search(lo, hi, rand_value()));
            continue;
          end
          1: begin
            lo = $urandom_range(0, 1) ? 0 : $urandom_range(0, bsc_pkg::DEPTH - 1);
            hi = $urandom_range(0, 1) ? bsc_pkg::DEPTH - 1
                                      : $urandom_range(lo, bsc_pkg::DEPTH - 1);
            if (add_search(lo, hi, vals[$urandom_range(0, n - 1)])) continue;
          end
          default: ;
        endcase
        lo = base + $urandom_range(0, n - 1);
        hi = base + $urandom_range(lo - base, n - 1);
        j  = $urandom_range(lo - base, hi - base);
        case ($urandom_range(0, 9))
          7:       key = rand_value();
          8:       key = vals[j] + 1;
          9:       key = vals[j] - 1;
          default: key = vals[j];
        endcase
        void'(add_search(lo, hi, key));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    do @(negedge clk);
    while (req_backlog.size() != 0 || start || search_results_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/bsc_pkg.sv
rtl/bsc_ram.sv
rtl/bsc_ctrl.sv
rtl/bsc_dp.sv
rtl/sorted_array_binary_search_core.sv
tb/tb.sv
